@@ src/tcw_pkg.sv @@
// Text console writer package: character codes, colour attributes and the
// placement flag struct shared by the placement logic and the top level.
// No dependencies.
package tcw_pkg;

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;

  localparam int unsigned TAB_STEP = 4;

  localparam logic [15:0] BLANK_CELL = 16'h0020;
  localparam logic [15:0] ZERO_CELL  = 16'h0000;

  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  localparam logic [2:0] HUE_WHITE  = 3'd0;
  localparam logic [2:0] HUE_GRAY   = 3'd1;
  localparam logic [2:0] HUE_YELLOW = 3'd2;
  localparam logic [2:0] HUE_RED    = 3'd3;
  localparam logic [2:0] HUE_BLUE   = 3'd4;
  localparam logic [2:0] HUE_GREEN  = 3'd5;

  localparam logic [15:0] ATTR_WHITE  = 16'h0F00;
  localparam logic [15:0] ATTR_GRAY   = 16'h0700;
  localparam logic [15:0] ATTR_YELLOW = 16'h0E00;
  localparam logic [15:0] ATTR_RED    = 16'h0C00;
  localparam logic [15:0] ATTR_BLUE   = 16'h0900;
  localparam logic [15:0] ATTR_GREEN  = 16'h0A00;

  typedef struct packed {
    logic write_cell;
    logic scroll;
  } place_flags_t;

  function automatic logic [15:0] attr_of(input logic [2:0] color);
    logic [15:0] attr;
    unique case (color)
      HUE_WHITE:  attr = ATTR_WHITE;
      HUE_GRAY:   attr = ATTR_GRAY;
      HUE_YELLOW: attr = ATTR_YELLOW;
      HUE_RED:    attr = ATTR_RED;
      HUE_BLUE:   attr = ATTR_BLUE;
      HUE_GREEN:  attr = ATTR_GREEN;
      default:    attr = ATTR_WHITE;
    endcase
    return attr;
  endfunction

endpackage

@@ src/tcw_place.sv @@
// Cursor placement for one put transfer: control characters, column wrap and
// scroll detection. Combinational; depends on tcw_pkg.
module tcw_place
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25,
  localparam int COL_W  = $clog2(COLUMNS + 1),
  localparam int ROW_W  = $clog2(ROWS)
) (
  input  logic [COL_W-1:0] cur_col,
  input  logic [ROW_W-1:0] cur_line,
  input  logic [7:0]       char_code,
  output logic [COL_W-1:0] col_o,
  output logic [ROW_W-1:0] line_o,
  output place_flags_t     flags_o
);

  localparam int CT_W = COL_W + 3;

  logic [CT_W-1:0]  col_t;
  logic [ROW_W:0]   line_t;

  always_comb begin
    col_t   = CT_W'(cur_col);
    line_t  = {1'b0, cur_line};
    flags_o = '0;
    if (char_code != CH_CR) begin
      flags_o.write_cell = 1'b1;
      if (char_code == CH_LF) begin
        col_t              = '0;
        line_t             = line_t + 1'b1;
        flags_o.write_cell = 1'b0;
      end else if (char_code == CH_TAB) begin
        col_t              = col_t + CT_W'(TAB_STEP);
        flags_o.write_cell = 1'b0;
      end
      if (col_t >= CT_W'(COLUMNS)) begin
        col_t  = '0;
        line_t = line_t + 1'b1;
      end
      if (line_t >= (ROW_W + 1)'(ROWS)) begin
        line_t         = (ROW_W + 1)'(ROWS - 1);
        flags_o.scroll = 1'b1;
      end
    end
    col_o  = col_t[COL_W-1:0];
    line_o = line_t[ROW_W-1:0];
  end

endmodule

@@ src/text_console_writer_unit.sv @@
// Text console writer top level: command channel, cell memory with a row ring,
// scroll sweep and reset clearing pass. Depends on tcw_pkg and tcw_place.
//
// Usage:
//   Drive the item on the in_ ports and raise start; the transfer happens at a
//   rising edge with start high and busy low. One result per item appears on
//   the out_ ports for exactly one cycle, marked by out_valid; the receiver
//   cannot stall, so it must take the result in that cycle.
//   Before out_valid, a put without scroll passes S_EXEC; a read, S_EXEC and
//   S_READ; a put that scrolls, S_EXEC, S_SCROLL (the blank row is written one
//   cell per cycle through the single write port of the cell memory) and
//   S_TAIL. A new item may be transferred in the cycle that out_valid is high.
//   Scrolling moves a row offset, so only the new last row is written.
//   cfg_wr_en/cfg_wr_data write tty_enabled; write only while idle.
//   Reset: synchronous, active low. After reset the cell memory is swept to
//   zero one cell per cycle, all ROWS * COLUMNS cells, with busy high; the
//   cursor and row offset return to zero and tty_enabled to 1.
module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_mode,
  input  logic [7:0]  in_char_code,
  input  logic [2:0]  in_color,
  input  logic [4:0]  in_row,
  input  logic [6:0]  in_column,
  input  logic        in_end_of_text,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  output logic        out_valid,
  output logic [15:0] out_cell_data,
  output logic [6:0]  out_cursor_column,
  output logic [4:0]  out_cursor_row,
  output logic        out_accepted,
  output logic        out_scrolled
);

  localparam int COL_W  = $clog2(COLUMNS + 1);
  localparam int CIDX_W = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_EXEC   = 3'd2;
  localparam logic [2:0] S_READ   = 3'd3;
  localparam logic [2:0] S_SCROLL = 3'd4;
  localparam logic [2:0] S_TAIL   = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [CIDX_W-1:0] scol_r, scol_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ROW_W-1:0]  sweep_row_r, sweep_row_nxt;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_line_r, cur_line_nxt;
  logic              tty_en_r, tty_en_nxt;
  logic              pend_r, pend_nxt;
  logic [CIDX_W-1:0] pend_col_r, pend_col_nxt;
  logic [15:0]       pend_data_r, pend_data_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic              valid_r, valid_nxt;
  logic [15:0]       cell_r, cell_nxt;
  logic              acc_r, acc_nxt;
  logic              scr_r, scr_nxt;

  logic              mode_r;
  logic [7:0]        char_r;
  logic [2:0]        color_r;
  logic [4:0]        row_r;
  logic [6:0]        column_r;

  logic [15:0]       mem [0:DEPTH-1];
  logic [15:0]       mem_q_r;
  logic              wr_en;
  logic [ROW_W-1:0]  wr_row;
  logic [CIDX_W-1:0] wr_col;
  logic [15:0]       wr_data;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic              rd_in_range;

  logic [COL_W-1:0]  pl_col;
  logic [ROW_W-1:0]  pl_line;
  place_flags_t      pl_flags;
  logic [15:0]       put_cell;

  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] lrow,
                                                input logic [ROW_W-1:0] top);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, top};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  tcw_place #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_place (
    .cur_col   (cur_col_r),
    .cur_line  (cur_line_r),
    .char_code (char_r),
    .col_o     (pl_col),
    .line_o    (pl_line),
    .flags_o   (pl_flags)
  );

  assign put_cell    = attr_of(color_r) | {8'h00, char_r};
  assign rd_in_range = (32'(row_r) < ROWS) && (32'(column_r) < COLUMNS);
  assign rd_addr     = ADDR_W'(phys_row(ROW_W'(row_r), top_r)) * ADDR_W'(COLUMNS)
                     + ADDR_W'(CIDX_W'(column_r));
  assign wr_addr     = (state_r == S_CLEAR) ? clr_cnt_r
                     : ADDR_W'(wr_row) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);

  always_comb begin
    wr_en   = 1'b0;
    wr_row  = sweep_row_r;
    wr_col  = scol_r;
    wr_data = ZERO_CELL;
    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_EXEC: begin
        wr_en   = (mode_r == MODE_PUT) && tty_en_r && pl_flags.write_cell
                  && !pl_flags.scroll;
        wr_row  = phys_row(pl_line, top_r);
        wr_col  = CIDX_W'(pl_col);
        wr_data = put_cell;
      end
      S_SCROLL: begin
        wr_en   = 1'b1;
        wr_data = BLANK_CELL;
      end
      S_TAIL: begin
        wr_en   = pend_r;
        wr_col  = pend_col_r;
        wr_data = pend_data_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    scol_nxt      = scol_r;
    top_nxt       = top_r;
    sweep_row_nxt = sweep_row_r;
    cur_col_nxt   = cur_col_r;
    cur_line_nxt  = cur_line_r;
    tty_en_nxt    = cfg_wr_en ? cfg_wr_data : tty_en_r;
    pend_nxt      = pend_r;
    pend_col_nxt  = pend_col_r;
    pend_data_nxt = pend_data_r;
    rd_ok_nxt     = rd_ok_r;
    valid_nxt     = 1'b0;
    cell_nxt      = cell_r;
    acc_nxt       = acc_r;
    scr_nxt       = scr_r;
    unique case (state_r)
      S_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode_r == MODE_READ) begin
          rd_ok_nxt = rd_in_range;
          state_nxt = S_READ;
        end else if (!tty_en_r) begin
          valid_nxt = 1'b1;
          cell_nxt  = ZERO_CELL;
          acc_nxt   = 1'b0;
          scr_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cur_line_nxt = pl_line;
          cur_col_nxt  = pl_flags.write_cell ? pl_col + COL_W'(1) : pl_col;
          if (pl_flags.scroll) begin
            top_nxt       = (top_r == ROW_W'(ROWS - 1)) ? '0 : top_r + 1'b1;
            sweep_row_nxt = top_r;
            scol_nxt      = '0;
            pend_nxt      = pl_flags.write_cell;
            pend_col_nxt  = CIDX_W'(pl_col);
            pend_data_nxt = put_cell;
            state_nxt     = S_SCROLL;
          end else begin
            valid_nxt = 1'b1;
            cell_nxt  = ZERO_CELL;
            acc_nxt   = 1'b1;
            scr_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end
      end
      S_READ: begin
        valid_nxt = 1'b1;
        cell_nxt  = rd_ok_r ? mem_q_r : ZERO_CELL;
        acc_nxt   = rd_ok_r && tty_en_r;
        scr_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      S_SCROLL: begin
        scol_nxt = scol_r + 1'b1;
        if (scol_r == CIDX_W'(COLUMNS - 1)) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        valid_nxt = 1'b1;
        cell_nxt  = ZERO_CELL;
        acc_nxt   = 1'b1;
        scr_nxt   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      top_r      <= '0;
      cur_col_r  <= '0;
      cur_line_r <= '0;
      tty_en_r   <= 1'b1;
      valid_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      top_r      <= top_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_line_r <= cur_line_nxt;
      tty_en_r   <= tty_en_nxt;
      valid_r    <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scol_r      <= scol_nxt;
    sweep_row_r <= sweep_row_nxt;
    pend_r      <= pend_nxt;
    pend_col_r  <= pend_col_nxt;
    pend_data_r <= pend_data_nxt;
    rd_ok_r     <= rd_ok_nxt;
    cell_r      <= cell_nxt;
    acc_r       <= acc_nxt;
    scr_r       <= scr_nxt;
    if (state_r == S_IDLE && start) begin
      mode_r   <= in_mode;
      char_r   <= in_char_code;
      color_r  <= in_color;
      row_r    <= in_row;
      column_r <= in_column;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q_r <= mem[rd_addr];
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = valid_r;
  assign out_cell_data     = cell_r;
  assign out_cursor_column = 7'(cur_col_r);
  assign out_cursor_row    = 5'(cur_line_r);
  assign out_accepted      = acc_r;
  assign out_scrolled      = scr_r;

`ifndef SYNTHESIS
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && scr_r) |-> (cur_line_r == ROW_W'(ROWS - 1)))
    else $error("scroll left cursor off the last row");

  a_scroll_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !acc_r) |-> !scr_r)
    else $error("scroll reported on a dropped transfer");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(top_r) < ROWS) && (32'(cur_line_r) < ROWS))
    else $error("row offset or cursor row out of range");
`endif

endmodule

@@ test/text_console_writer_unit_test.sv @@
// Testbench for text_console_writer_unit: a directed script and random command
// traffic checked against a behavioral console model, with the enable toggled
// between phases. Depends on tcw_pkg and the text_console_writer_unit RTL.
module text_console_writer_unit_test
  import tcw_pkg::*;
();

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam logic [2:0] COLOR_RSVD  = 3'd6;
  localparam logic [2:0] COLOR_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = COLS + 8;
  localparam int WATCHDOG_LIMIT = 10000;
  localparam int SCRIPT_LEN = 24;
  localparam int PHASES = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] ch;
    logic [2:0] color;
    logic [4:0] row;
    logic [6:0] column;
    logic       eot;
  } console_cmd_t;

  typedef struct packed {
    logic [15:0] cdata;
    logic [6:0]  col;
    logic [4:0]  line;
    logic        acc;
    logic        scr;
  } console_view_t;

  typedef struct packed {
    console_cmd_t  cmd;
    logic [5:0]    reps;
    logic          typed;
    console_view_t view;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_mode = MODE_PUT;
  logic [7:0]  in_char_code = 8'h00;
  logic [2:0]  in_color = HUE_WHITE;
  logic [4:0]  in_row = 5'd0;
  logic [6:0]  in_column = 7'd0;
  logic        in_end_of_text = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        out_valid;
  logic [15:0] out_cell_data;
  logic [6:0]  out_cursor_column;
  logic [4:0]  out_cursor_row;
  logic        out_accepted;
  logic        out_scrolled;

  text_console_writer_unit #(.COLUMNS(COLS), .ROWS(ROWS)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_char_code      (in_char_code),
    .in_color          (in_color),
    .in_row            (in_row),
    .in_column         (in_column),
    .in_end_of_text    (in_end_of_text),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_cell_data     (out_cell_data),
    .out_cursor_column (out_cursor_column),
    .out_cursor_row    (out_cursor_row),
    .out_accepted      (out_accepted),
    .out_scrolled      (out_scrolled)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [15:0]   screen_model [0:ROWS-1][0:COLS-1];
  logic [15:0]   attr_lut [0:7];
  int unsigned   cur_col;
  int unsigned   cur_line;
  logic          tty_on;
  console_view_t expected_views [$];
  script_row_t   script [0:SCRIPT_LEN-1];
  int            fails = 0;
  int            idle_cycles = 0;
  int            n_reads = 0;
  int            n_puts = 0;
  int            n_scrolls = 0;
  int            n_ignored = 0;
  int            n_checked = 0;

  task automatic reset_console_model();
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        screen_model[r][c] = ZERO_CELL;
      end
    end
    cur_col = 0;
    cur_line = 0;
    tty_on = 1'b1;
    attr_lut[HUE_WHITE] = ATTR_WHITE;
    attr_lut[HUE_GRAY] = ATTR_GRAY;
    attr_lut[HUE_YELLOW] = ATTR_YELLOW;
    attr_lut[HUE_RED] = ATTR_RED;
    attr_lut[HUE_BLUE] = ATTR_BLUE;
    attr_lut[HUE_GREEN] = ATTR_GREEN;
    attr_lut[COLOR_RSVD] = ATTR_WHITE;
    attr_lut[COLOR_SPARE] = ATTR_WHITE;
  endtask

  task automatic predict_console(input console_cmd_t c, output console_view_t v);
    logic moved_only;
    moved_only = 1'b0;
    v = '0;
    if (c.mode == MODE_READ) begin
      n_reads++;
      if (c.row < ROWS && c.column < COLS) begin
        v.cdata = screen_model[c.row][c.column];
        v.acc = tty_on;
      end
    end else if (!tty_on) begin
      n_ignored++;
    end else begin
      n_puts++;
      v.acc = 1'b1;
      if (c.ch != CH_CR) begin
        if (c.ch == CH_LF) begin
          cur_line++;
          cur_col = 0;
          moved_only = 1'b1;
        end else if (c.ch == CH_TAB) begin
          cur_col += TAB_STEP;
          moved_only = 1'b1;
        end
        if (cur_col >= COLS) begin
          cur_col = 0;
          cur_line++;
        end
        if (cur_line >= ROWS) begin
          cur_line = ROWS - 1;
          for (int r = 0; r < ROWS - 1; r++) begin
            for (int k = 0; k < COLS; k++) begin
              screen_model[r][k] = screen_model[r+1][k];
            end
          end
          for (int k = 0; k < COLS; k++) begin
            screen_model[ROWS-1][k] = BLANK_CELL;
          end
          v.scr = 1'b1;
          n_scrolls++;
        end
        if (!moved_only) begin
          screen_model[cur_line][cur_col] = attr_lut[c.color] | {8'h00, c.ch};
          cur_col++;
        end
      end
    end
    v.col = cur_col[6:0];
    v.line = cur_line[4:0];
  endtask

  // Drive one command, hold it until the transfer, then, if gap is nonzero, drop start and idle for the gap.
  task automatic send_cmd(input console_cmd_t c, input int gap, input logic typed,
                          input console_view_t typed_view);
    console_view_t v;
    in_mode <= c.mode;
    in_char_code <= c.ch;
    in_color <= c.color;
    in_row <= c.row;
    in_column <= c.column;
    in_end_of_text <= c.eot;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_console(c, v);
    expected_views.push_back(typed ? typed_view : v);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (expected_views.size() != 0) @(posedge clk);
  endtask

  task automatic write_tty_enable(input logic value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tty_on = value;
  endtask

  function automatic console_cmd_t random_cmd();
    console_cmd_t c;
    int pick;
    c.mode = ($urandom_range(0, 9) < 3) ? MODE_READ : MODE_PUT;
    pick = $urandom_range(0, 99);
    if (pick < 14) c.ch = CH_LF;
    else if (pick < 22) c.ch = CH_TAB;
    else if (pick < 26) c.ch = CH_CR;
    else c.ch = 8'($urandom_range(0, 255));
    c.color = 3'($urandom_range(0, 7));
    c.row = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
            5'($urandom_range(0, ROWS - 1));
    c.column = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127)) :
               7'($urandom_range(0, COLS - 1));
    c.eot = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic script_row_t script_row(
      input logic mode, input logic [7:0] ch, input logic [2:0] color,
      input logic [4:0] row, input logic [6:0] column, input logic eot,
      input int reps, input logic typed, input logic [15:0] cdata,
      input logic [6:0] col, input logic [4:0] line, input logic acc, input logic scr);
    script_row_t s;
    s.cmd = '{mode, ch, color, row, column, eot};
    s.reps = 6'(reps);
    s.typed = typed;
    s.view = '{cdata, col, line, acc, scr};
    return s;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    console_view_t exp_v;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual cell %0h col %0d row %0d",
                 $time, out_cell_data, out_cursor_column, out_cursor_row);
        fails++;
      end else begin
        exp_v = expected_views.pop_front();
        n_checked++;
        check_field("cell_data", 32'(exp_v.cdata), 32'(out_cell_data));
        check_field("cursor_column", 32'(exp_v.col), 32'(out_cursor_column));
        check_field("cursor_row", 32'(exp_v.line), 32'(out_cursor_row));
        check_field("accepted", 32'(exp_v.acc), 32'(out_accepted));
        check_field("scrolled", 32'(exp_v.scr), 32'(out_scrolled));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding", $time,
               expected_views.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int phase_len [PHASES];
    logic phase_en [PHASES];
    int gap;
    int total;
    int scripted;
    script[0]  = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd0, 5'd0, 1'b1, 1'b0);
    script[1]  = script_row(MODE_READ, 8'hFF, COLOR_SPARE, 5'd31, 7'd127, 1'b1, 1, 1'b1,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[2]  = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd24, 7'd79, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd0, 5'd0, 1'b1, 1'b0);
    script[3]  = script_row(MODE_PUT, 8'h41, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd1, 5'd0, 1'b1, 1'b0);
    script[4]  = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ATTR_WHITE | 16'h0041, 7'd1, 5'd0, 1'b1, 1'b0);
    script[5]  = script_row(MODE_PUT, CH_CR, HUE_RED, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd1, 5'd0, 1'b1, 1'b0);
    script[6]  = script_row(MODE_PUT, CH_TAB, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd5, 5'd0, 1'b1, 1'b0);
    script[7]  = script_row(MODE_PUT, 8'hFF, COLOR_SPARE, 5'd31, 7'd127, 1'b1, 1, 1'b1,
                            ZERO_CELL, 7'd6, 5'd0, 1'b1, 1'b0);
    script[8]  = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd0, 7'd5, 1'b0, 1, 1'b1,
                            ATTR_WHITE | 16'h00FF, 7'd6, 5'd0, 1'b1, 1'b0);
    script[9]  = script_row(MODE_PUT, CH_LF, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd0, 5'd1, 1'b1, 1'b0);
    script[10] = script_row(MODE_PUT, 8'h00, HUE_GREEN, 5'd0, 7'd0, 1'b0, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[11] = script_row(MODE_PUT, 8'h62, HUE_GRAY, 5'd0, 7'd0, 1'b0, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[12] = script_row(MODE_PUT, 8'h7F, HUE_YELLOW, 5'd0, 7'd0, 1'b0, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[13] = script_row(MODE_PUT, 8'h80, HUE_RED, 5'd0, 7'd0, 1'b0, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[14] = script_row(MODE_PUT, 8'h20, HUE_BLUE, 5'd0, 7'd0, 1'b1, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[15] = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd1, 7'd0, 1'b0, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[16] = script_row(MODE_PUT, CH_LF, HUE_WHITE, 5'd0, 7'd0, 1'b0, 23, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[17] = script_row(MODE_PUT, CH_LF, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd0, 5'd24, 1'b1, 1'b1);
    script[18] = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd24, 7'd0, 1'b0, 1, 1'b1,
                            BLANK_CELL, 7'd0, 5'd24, 1'b1, 1'b0);
    script[19] = script_row(MODE_PUT, CH_TAB, HUE_WHITE, 5'd0, 7'd0, 1'b0, 19, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[20] = script_row(MODE_PUT, 8'h63, HUE_GREEN, 5'd0, 7'd0, 1'b0, 4, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[21] = script_row(MODE_PUT, CH_TAB, HUE_WHITE, 5'd0, 7'd0, 1'b0, 1, 1'b1,
                            ZERO_CELL, 7'd0, 5'd24, 1'b1, 1'b1);
    script[22] = script_row(MODE_READ, 8'h00, HUE_WHITE, 5'd23, 7'd79, 1'b0, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    script[23] = script_row(MODE_PUT, 8'h64, HUE_RED, 5'd0, 7'd0, 1'b1, 1, 1'b0,
                            ZERO_CELL, 7'd0, 5'd0, 1'b0, 1'b0);
    phase_len = '{200, 900, 150, 700};
    phase_en = '{1'b0, 1'b1, 1'b0, 1'b1};

    reset_console_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    scripted = 0;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      for (int k = 0; k < script[i].reps; k++) begin
        gap = (i == SCRIPT_LEN - 1) ? 1 : $urandom_range(0, 11);
        send_cmd(script[i].cmd, gap, script[i].typed, script[i].view);
        scripted++;
      end
    end

    write_tty_enable(1'b1);
    total = 0;
    for (int p = 0; p < PHASES; p++) begin
      write_tty_enable(phase_en[p]);
      for (int i = 0; i < phase_len[p]; i++) begin
        if ((i / 48) % 4 == 3) gap = 0;
        else gap = $urandom_range(0, 11);
        if (i == phase_len[p] - 1 || i == phase_len[p] / 2) gap = gap + 1;
        send_cmd(random_cmd(), gap, 1'b0, '0);
        if (p == 1 && i == phase_len[p] / 2) drain_results();
        total++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d results over %0d random and %0d scripted commands,", n_checked,
             total, scripted);
    $display("%0d reads, %0d puts, %0d scrolls, %0d puts dropped while disabled.",
             n_reads, n_puts, n_scrolls, n_ignored);
    if (fails == 0 && expected_views.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
